[rtl/mdms_pkg.sv]
// Shared types and constants of the mailbox doorbell message sender.
package mdms_pkg;

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_PAYLOAD,
        PH_WAIT_FREE,
        PH_WAIT_ACK
    } phase_t;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_STATUS  = 2'd2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_DONE  = 2'd2;
    localparam logic [1:0] ACT_ERROR = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTIFY_PATTERN = 2'd1;

    localparam logic [7:0]  CHANNEL_COUNT_RESET  = 8'd16;
    localparam logic [31:0] NOTIFY_PATTERN_RESET = 32'd1234;
    localparam logic [31:0] BYTES_PER_WORD       = 32'd4;

    // Result pairs buffered between the framer and the output port.
    localparam int PAIR_DEPTH = 2;

    typedef struct packed
    {
        logic [1:0]  mode;
        logic [31:0] message_bytes;
        logic [31:0] payload_word;
        logic [31:0] status_word;
    } item_t;

    typedef struct packed
    {
        logic [1:0]  action;
        logic [6:0]  channel_index;
        logic [31:0] write_value;
        logic        last_of_run;
    } result_t;

    typedef struct packed
    {
        logic [7:0]  channel_count;
        logic [31:0] notify_pattern;
    } cfg_t;

    function automatic result_t make_result(logic [1:0] act, logic [6:0] ch,
                                            logic [31:0] val, logic last);
        result_t r;
        r.action        = act;
        r.channel_index = ch;
        r.write_value   = val;
        r.last_of_run   = last;
        return r;
    endfunction

endpackage

[rtl/mdms_framer.sv]
// Message framing state machine: turns one item into up to two results.
module mdms_framer #(
    parameter int MAX_CHANNELS = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  mdms_pkg::item_t        item,
    input  mdms_pkg::cfg_t         cfg,
    input  logic                   consume,
    output mdms_pkg::result_t [1:0] res,
    output logic [1:0]             res_cnt
);

    localparam logic [7:0] MAX_CH = 8'(MAX_CHANNELS);

    mdms_pkg::phase_t phase_reg, phase_next;
    logic [6:0]       chan_reg, chan_next;
    logic [31:0]      bytes_reg, bytes_next;

    logic [6:0]  last_ch;
    logic        busy;
    logic [31:0] bytes_dec;
    logic [6:0]  chan_inc;

    always_comb
    begin
        if (cfg.channel_count < 8'd2)
        begin
            last_ch = 7'd1;
        end
        else if (cfg.channel_count > MAX_CH)
        begin
            last_ch = 7'(MAX_CH - 8'd1);
        end
        else
        begin
            last_ch = 7'(cfg.channel_count - 8'd1);
        end
    end

    // A pattern of zero always reads as busy.
    assign busy      = (item.status_word & cfg.notify_pattern) == cfg.notify_pattern;
    assign bytes_dec = (bytes_reg > mdms_pkg::BYTES_PER_WORD) ?
                       bytes_reg - mdms_pkg::BYTES_PER_WORD : 32'd0;
    assign chan_inc  = chan_reg + 7'd1;

    always_comb
    begin
        phase_next = phase_reg;
        chan_next  = chan_reg;
        bytes_next = bytes_reg;
        res[0]     = mdms_pkg::make_result(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1);
        res[1]     = mdms_pkg::make_result(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1);
        res_cnt    = 2'd1;

        if (item.mode == mdms_pkg::MODE_START && phase_reg == mdms_pkg::PH_IDLE)
        begin
            if (item.message_bytes == 32'd0)
            begin
                res[0] = mdms_pkg::make_result(mdms_pkg::ACT_DONE, 7'd0, 32'd0, 1'b1);
            end
            else
            begin
                bytes_next = item.message_bytes;
                chan_next  = 7'd1;
                if (last_ch == 7'd1)
                begin
                    phase_next = mdms_pkg::PH_WAIT_FREE;
                    res[0]  = mdms_pkg::make_result(mdms_pkg::ACT_WRITE, 7'd0,
                                                    item.message_bytes, 1'b0);
                    res[1]  = mdms_pkg::make_result(mdms_pkg::ACT_READ, last_ch,
                                                    32'd0, 1'b1);
                    res_cnt = 2'd2;
                end
                else
                begin
                    phase_next = mdms_pkg::PH_PAYLOAD;
                    res[0]  = mdms_pkg::make_result(mdms_pkg::ACT_WRITE, 7'd0,
                                                    item.message_bytes, 1'b1);
                end
            end
        end
        else if (item.mode == mdms_pkg::MODE_PAYLOAD && phase_reg == mdms_pkg::PH_PAYLOAD)
        begin
            bytes_next = bytes_dec;
            chan_next  = chan_inc;
            if (chan_inc == last_ch || bytes_dec == 32'd0)
            begin
                phase_next = mdms_pkg::PH_WAIT_FREE;
                res[0]  = mdms_pkg::make_result(mdms_pkg::ACT_WRITE, chan_reg,
                                                item.payload_word, 1'b0);
                res[1]  = mdms_pkg::make_result(mdms_pkg::ACT_READ, last_ch, 32'd0, 1'b1);
                res_cnt = 2'd2;
            end
            else
            begin
                res[0] = mdms_pkg::make_result(mdms_pkg::ACT_WRITE, chan_reg,
                                               item.payload_word, 1'b1);
            end
        end
        else if (item.mode == mdms_pkg::MODE_STATUS && phase_reg == mdms_pkg::PH_WAIT_FREE)
        begin
            if (busy)
            begin
                res[0] = mdms_pkg::make_result(mdms_pkg::ACT_READ, last_ch, 32'd0, 1'b1);
            end
            else
            begin
                phase_next = mdms_pkg::PH_WAIT_ACK;
                res[0]  = mdms_pkg::make_result(mdms_pkg::ACT_WRITE, last_ch,
                                                cfg.notify_pattern, 1'b0);
                res[1]  = mdms_pkg::make_result(mdms_pkg::ACT_READ, last_ch, 32'd0, 1'b1);
                res_cnt = 2'd2;
            end
        end
        else if (item.mode == mdms_pkg::MODE_STATUS && phase_reg == mdms_pkg::PH_WAIT_ACK)
        begin
            if (busy)
            begin
                res[0] = mdms_pkg::make_result(mdms_pkg::ACT_READ, last_ch, 32'd0, 1'b1);
            end
            else
            begin
                chan_next = 7'd0;
                if (bytes_reg == 32'd0)
                begin
                    phase_next = mdms_pkg::PH_IDLE;
                    res[0] = mdms_pkg::make_result(mdms_pkg::ACT_DONE, 7'd0, 32'd0, 1'b1);
                end
                else
                begin
                    // Receiver took the fragment; more data follows from channel 0.
                    phase_next = mdms_pkg::PH_PAYLOAD;
                    res_cnt    = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mdms_pkg::PH_IDLE;
            chan_reg  <= 7'd0;
            bytes_reg <= 32'd0;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
            bytes_reg <= bytes_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mdms_pkg::PH_IDLE |-> bytes_reg == 32'd0)
        else $error("idle phase with bytes still pending");

    a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mdms_pkg::PH_PAYLOAD |-> bytes_reg != 32'd0)
        else $error("payload phase with no bytes left");

    a_silent_only_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && res_cnt == 2'd0 |-> phase_reg == mdms_pkg::PH_WAIT_ACK)
        else $error("transaction without result outside the acknowledge poll");
`endif

endmodule

[rtl/mdms_out_queue.sv]
// Queue of result pairs, shown one result at a time on the output port.
module mdms_out_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mdms_pkg::result_t [1:0] push_pair,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output mdms_pkg::result_t       head
);

    localparam int PTR_W = (mdms_pkg::PAIR_DEPTH > 1) ? $clog2(mdms_pkg::PAIR_DEPTH) : 1;
    localparam int CNT_W = $clog2(mdms_pkg::PAIR_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mdms_pkg::PAIR_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(mdms_pkg::PAIR_DEPTH);

    mdms_pkg::result_t [1:0] pair_mem_reg [mdms_pkg::PAIR_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             sub_reg, sub_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign head      = pair_mem_reg[rd_ptr_reg][sub_reg];
    assign pop       = out_valid && out_ready && head.last_of_run;
    assign room      = count_reg < CNT_FULL || pop;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (out_valid && out_ready)
        begin
            sub_next = !pop;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pair_mem_reg[wr_ptr_reg] <= push_pair;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("result queue overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("result pair pushed into a full queue");

    a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sub_reg |-> head.last_of_run)
        else $error("second result of a pair is not the last of its run");
`endif

endmodule

[rtl/mailbox_doorbell_message_sender_top.sv]
// Each result is registered in the input stage and then in the result queue.
// Throughput: one input transaction per cycle while the result queue has room; two
// results of an item leave in turn; the two-pair queue sets how far input runs ahead.
// Reset (rst_n, asynchronous, active low): idle phase, queue empty, channel count 16,
// notify pattern 1234. No clearing pass is needed.
module mailbox_doorbell_message_sender_top #(
    parameter int MAX_CHANNELS = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       mode,
    input  logic [31:0]                      message_bytes,
    input  logic [31:0]                      payload_word,
    input  logic [31:0]                      status_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       action,
    output logic [6:0]                       channel_index,
    output logic [31:0]                      write_value,
    output logic                             last_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mdms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    logic              in_valid_reg;
    mdms_pkg::item_t   item_reg;
    mdms_pkg::cfg_t    cfg_reg;
    logic              consume;
    logic              room;
    logic              in_take;
    logic [1:0]        res_cnt;
    mdms_pkg::result_t [1:0] res;
    mdms_pkg::result_t head;

    assign cfg_ready = 1'b1;
    assign consume   = in_valid_reg && room;
    assign in_ready  = !in_valid_reg || consume;
    assign in_take   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode          <= mode;
            item_reg.message_bytes <= message_bytes;
            item_reg.payload_word  <= payload_word;
            item_reg.status_word   <= status_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count  <= mdms_pkg::CHANNEL_COUNT_RESET;
            cfg_reg.notify_pattern <= mdms_pkg::NOTIFY_PATTERN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mdms_pkg::CFG_CHANNEL_COUNT:  cfg_reg.channel_count  <= cfg_data[7:0];
                mdms_pkg::CFG_NOTIFY_PATTERN: cfg_reg.notify_pattern <= cfg_data;
                default: ;
            endcase
        end
    end

    mdms_framer #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .consume    (consume),
        .res        (res),
        .res_cnt    (res_cnt)
    );

    mdms_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (consume && res_cnt != 2'd0),
        .push_pair (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign action        = head.action;
    assign channel_index = head.channel_index;
    assign write_value   = head.write_value;
    assign last_of_run   = head.last_of_run;

endmodule

[verif/tb_mailbox_doorbell_message_sender_top.sv]
// Self-checking testbench of the mailbox doorbell message sender top level.
`timescale 1ns / 1ps

module tb_mailbox_doorbell_message_sender_top;

    localparam int MAX_CHANNELS    = 128;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 143;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [1:0]        MODE_ILLEGAL = 2'd3;
    localparam mdms_pkg::result_t NO_RESULT    = '0;

    typedef enum logic
    {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct
    {
        row_kind_t                        kind;
        mdms_pkg::item_t                  it;
        logic [mdms_pkg::CFG_INDEX_W-1:0] idx;
        logic [31:0]                      data;
        int                               n_typed;
        mdms_pkg::result_t                t0;
        mdms_pkg::result_t                t1;
    } dir_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [1:0]                       mode;
    logic [31:0]                      message_bytes;
    logic [31:0]                      payload_word;
    logic [31:0]                      status_word;
    logic                             out_valid;
    logic                             out_ready;
    logic [1:0]                       action;
    logic [6:0]                       channel_index;
    logic [31:0]                      write_value;
    logic                             last_of_run;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [mdms_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                      cfg_data;

    // Shadow of the framer: registers, phase, channel counter, bytes still to send.
    logic [7:0]        reg_chan_count;
    logic [31:0]       reg_pattern;
    mdms_pkg::phase_t  fr_phase;
    logic [6:0]        fr_chan;
    logic [31:0]       fr_left;

    mdms_pkg::result_t step_res [2];
    mdms_pkg::result_t pending_doorbell_ops [$];
    dir_row_t          dir_rows [$];

    int                cur_typed_n;
    mdms_pkg::result_t cur_t0;
    mdms_pkg::result_t cur_t1;
    int                errors;
    int                quiet_cycles;
    int                stall_left;
    bit                hold_req;
    bit                no_gaps;

    mailbox_doorbell_message_sender_top #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .message_bytes(message_bytes),
        .payload_word (payload_word),
        .status_word  (status_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .action       (action),
        .channel_index(channel_index),
        .write_value  (write_value),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic mdms_pkg::result_t res(logic [1:0] act, logic [6:0] ch,
                                              logic [31:0] val, logic last);
        mdms_pkg::result_t r;
        r.action        = act;
        r.channel_index = ch;
        r.write_value   = val;
        r.last_of_run   = last;
        return r;
    endfunction

    // The notify channel is the last implemented one; the count saturates at both ends.
    function automatic logic [6:0] notify_channel();
        logic [7:0] n;
        n = reg_chan_count;
        if (n < 8'd2)
            n = 8'd2;
        if (n > 8'(MAX_CHANNELS))
            n = 8'(MAX_CHANNELS);
        return 7'(n - 8'd1);
    endfunction

    function automatic bit notify_busy(logic [31:0] s);
        return (s & reg_pattern) == reg_pattern;
    endfunction

    // Advances the shadow framer by one item and leaves its results in step_res.
    function automatic int frame_item(mdms_pkg::item_t it);
        logic [6:0] last;
        int         n;
        last = notify_channel();
        n = 0;
        if (it.mode == mdms_pkg::MODE_START && fr_phase == mdms_pkg::PH_IDLE)
        begin
            if (it.message_bytes == 32'd0)
            begin
                step_res[n] = res(mdms_pkg::ACT_DONE, 7'd0, 32'd0, 1'b0);
                n++;
            end
            else
            begin
                step_res[n] = res(mdms_pkg::ACT_WRITE, 7'd0, it.message_bytes, 1'b0);
                n++;
                fr_left = it.message_bytes;
                fr_chan = 7'd1;
                if (fr_chan == last)
                begin
                    fr_phase = mdms_pkg::PH_WAIT_FREE;
                    step_res[n] = res(mdms_pkg::ACT_READ, last, 32'd0, 1'b0);
                    n++;
                end
                else
                    fr_phase = mdms_pkg::PH_PAYLOAD;
            end
        end
        else if (it.mode == mdms_pkg::MODE_PAYLOAD && fr_phase == mdms_pkg::PH_PAYLOAD)
        begin
            step_res[n] = res(mdms_pkg::ACT_WRITE, fr_chan, it.payload_word, 1'b0);
            n++;
            fr_left = (fr_left > mdms_pkg::BYTES_PER_WORD) ?
                      fr_left - mdms_pkg::BYTES_PER_WORD : 32'd0;
            fr_chan = fr_chan + 7'd1;
            if (fr_chan == last || fr_left == 32'd0)
            begin
                fr_phase = mdms_pkg::PH_WAIT_FREE;
                step_res[n] = res(mdms_pkg::ACT_READ, last, 32'd0, 1'b0);
                n++;
            end
        end
        else if (it.mode == mdms_pkg::MODE_STATUS && fr_phase == mdms_pkg::PH_WAIT_FREE)
        begin
            if (!notify_busy(it.status_word))
            begin
                step_res[n] = res(mdms_pkg::ACT_WRITE, last, reg_pattern, 1'b0);
                n++;
                fr_phase = mdms_pkg::PH_WAIT_ACK;
            end
            step_res[n] = res(mdms_pkg::ACT_READ, last, 32'd0, 1'b0);
            n++;
        end
        else if (it.mode == mdms_pkg::MODE_STATUS && fr_phase == mdms_pkg::PH_WAIT_ACK)
        begin
            if (notify_busy(it.status_word))
            begin
                step_res[n] = res(mdms_pkg::ACT_READ, last, 32'd0, 1'b0);
                n++;
            end
            else
            begin
                // A cleared notify channel with data left resumes silently on channel 0.
                fr_chan = 7'd0;
                if (fr_left == 32'd0)
                begin
                    fr_phase = mdms_pkg::PH_IDLE;
                    step_res[n] = res(mdms_pkg::ACT_DONE, 7'd0, 32'd0, 1'b0);
                    n++;
                end
                else
                    fr_phase = mdms_pkg::PH_PAYLOAD;
            end
        end
        else
        begin
            step_res[n] = res(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b0);
            n++;
        end
        if (n > 0)
            step_res[n - 1].last_of_run = 1'b1;
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly a well-formed next item for the current shadow phase, sometimes noise.
    function automatic mdms_pkg::item_t next_sender_item();
        mdms_pkg::item_t it;
        logic [6:0]      last;
        last = notify_channel();
        it.mode          = 2'($urandom_range(0, 3));
        it.message_bytes = $urandom;
        it.payload_word  = $urandom;
        it.status_word   = $urandom;
        if ($urandom_range(0, 99) < 10)
        begin
            // A huge accepted size would never finish, so noise starts stay small in idle.
            if (it.mode == mdms_pkg::MODE_START && fr_phase == mdms_pkg::PH_IDLE)
                it.message_bytes = $urandom_range(0, 8 * int'(last) + 8);
            return it;
        end
        case (fr_phase)
            mdms_pkg::PH_IDLE:
            begin
                it.mode = mdms_pkg::MODE_START;
                if ($urandom_range(0, 9) == 0)
                    it.message_bytes = 32'd0;
                else
                    it.message_bytes = $urandom_range(1, 8 * int'(last) + 8);
            end
            mdms_pkg::PH_PAYLOAD:
                it.mode = mdms_pkg::MODE_PAYLOAD;
            default:
            begin
                it.mode = mdms_pkg::MODE_STATUS;
                if ($urandom_range(0, 99) < 30)
                    it.status_word = it.status_word | reg_pattern;
                else
                    it.status_word = it.status_word & ~reg_pattern;
            end
        endcase
        return it;
    endfunction

    function automatic void row_item(logic [1:0] m, logic [31:0] msg, logic [31:0] word,
                                     logic [31:0] stat, int n_typed,
                                     mdms_pkg::result_t t0, mdms_pkg::result_t t1);
        dir_row_t row;
        row.kind             = ROW_ITEM;
        row.it.mode          = m;
        row.it.message_bytes = msg;
        row.it.payload_word  = word;
        row.it.status_word   = stat;
        row.idx              = '0;
        row.data             = '0;
        row.n_typed          = n_typed;
        row.t0               = t0;
        row.t1               = t1;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_cfg(logic [mdms_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [31:0] data);
        dir_row_t row;
        row.kind    = ROW_CFG;
        row.it      = '0;
        row.idx     = idx;
        row.data    = data;
        row.n_typed = 0;
        row.t0      = NO_RESULT;
        row.t1      = NO_RESULT;
        dir_rows.push_back(row);
    endfunction

    // Entered and left at a falling edge; valid stays high when items follow back to back.
    task automatic drive_item(mdms_pkg::item_t it, int n_typed, mdms_pkg::result_t t0,
                              mdms_pkg::result_t t1);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_typed_n    = n_typed;
        cur_t0         = t0;
        cur_t1         = t1;
        mode          <= it.mode;
        message_bytes <= it.message_bytes;
        payload_word  <= it.payload_word;
        status_word   <= it.status_word;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [mdms_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Waits until every expected result is out and any silent item has settled.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_doorbell_ops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        mdms_pkg::result_t want;
        int                n;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mdms_pkg::CFG_CHANNEL_COUNT)
                    reg_chan_count = cfg_data[7:0];
                else if (cfg_index == mdms_pkg::CFG_NOTIFY_PATTERN)
                    reg_pattern = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                n = frame_item('{mode, message_bytes, payload_word, status_word});
                if (cur_typed_n > 0)
                begin
                    pending_doorbell_ops.push_back(cur_t0);
                    if (cur_typed_n > 1)
                        pending_doorbell_ops.push_back(cur_t1);
                end
                else
                    for (int k = 0; k < n; k++)
                        pending_doorbell_ops.push_back(step_res[k]);
            end
            if (out_valid && out_ready)
            begin
                if (pending_doorbell_ops.size() == 0)
                begin
                    $error("result with nothing expected: action %0d channel %0d value %0h",
                           action, channel_index, write_value);
                    errors++;
                end
                else
                begin
                    want = pending_doorbell_ops.pop_front();
                    if (action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, action);
                        errors++;
                    end
                    if (channel_index !== want.channel_index)
                    begin
                        $error("channel_index: expected %0d, got %0d",
                               want.channel_index, channel_index);
                        errors++;
                    end
                    if (write_value !== want.write_value)
                    begin
                        $error("write_value: expected %0h, got %0h",
                               want.write_value, write_value);
                        errors++;
                    end
                    if (last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, last_of_run);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("mailbox_doorbell_message_sender_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random stalls, plus one long hold-off on request so the block backs up.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                out_ready <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
                hold_req = 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [7:0]  cc;
        logic [31:0] pat;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = mdms_pkg::MODE_START;
        message_bytes  = '0;
        payload_word   = '0;
        status_word    = '0;
        cfg_valid      = 1'b0;
        cfg_index      = mdms_pkg::CFG_CHANNEL_COUNT;
        cfg_data       = '0;
        reg_chan_count = mdms_pkg::CHANNEL_COUNT_RESET;
        reg_pattern    = mdms_pkg::NOTIFY_PATTERN_RESET;
        fr_phase       = mdms_pkg::PH_IDLE;
        fr_chan        = 7'd0;
        fr_left        = 32'd0;
        cur_typed_n    = 0;
        cur_t0         = NO_RESULT;
        cur_t1         = NO_RESULT;
        errors         = 0;
        quiet_cycles   = 0;
        hold_req       = 1'b0;
        no_gaps        = 1'b0;

        // Reset values: sixteen channels, notify on channel 15, pattern 1234.
        row_item(mdms_pkg::MODE_PAYLOAD, 0, 32'hFFFF_FFFF, 0, 1,
                 res(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1), NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'hFFFF_FFFF, 1,
                 res(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1), NO_RESULT);
        row_item(MODE_ILLEGAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                 res(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1), NO_RESULT);
        row_item(mdms_pkg::MODE_START, 0, 0, 0, 1,
                 res(mdms_pkg::ACT_DONE, 7'd0, 32'd0, 1'b1), NO_RESULT);
        row_item(mdms_pkg::MODE_START, 6, 0, 0, 1,
                 res(mdms_pkg::ACT_WRITE, 7'd0, 32'd6, 1'b1), NO_RESULT);
        row_item(mdms_pkg::MODE_START, 32'hFFFF_FFFF, 0, 0, 1,
                 res(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1), NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'hFFFF_FFFF, 1,
                 res(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1), NO_RESULT);
        row_item(mdms_pkg::MODE_PAYLOAD, 0, 32'hFFFF_FFFF, 0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_PAYLOAD, 0, 32'h0, 0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_PAYLOAD, 0, 32'h5A5A_5A5A, 0, 1,
                 res(mdms_pkg::ACT_ERROR, 7'd0, 32'd0, 1'b1), NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'hFFFF_FFFF, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'hFFFF_FFFF, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);
        // Two channels: the size write alone fills the fragment.
        row_cfg(mdms_pkg::CFG_CHANNEL_COUNT, 32'hFFFF_FF02);
        row_cfg(mdms_pkg::CFG_NOTIFY_PATTERN, 32'hFFFF_FFFF);
        row_item(mdms_pkg::MODE_START, 4, 0, 0, 2,
                 res(mdms_pkg::ACT_WRITE, 7'd0, 32'd4, 1'b0),
                 res(mdms_pkg::ACT_READ, 7'd1, 32'd0, 1'b1));
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h7FFF_FFFF, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_PAYLOAD, 0, 32'h1234_5678, 0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);
        // A zero pattern keeps the notify channel busy until the pattern changes.
        row_cfg(mdms_pkg::CFG_CHANNEL_COUNT, 32'd3);
        row_cfg(mdms_pkg::CFG_NOTIFY_PATTERN, 32'd0);
        row_item(mdms_pkg::MODE_START, 1, 0, 0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_PAYLOAD, 0, 32'hA5A5_A5A5, 0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);
        row_cfg(mdms_pkg::CFG_NOTIFY_PATTERN, mdms_pkg::NOTIFY_PATTERN_RESET);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);
        row_item(mdms_pkg::MODE_STATUS, 0, 0, 32'h0, 0, NO_RESULT, NO_RESULT);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
                cfg_valid <= 1'b0;
            end
            else
                drive_item(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].t0,
                           dir_rows[i].t1);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: begin cc = 8'd2;   pat = 32'hFFFF_FFFF; end
                1: begin cc = 8'd128; pat = 32'd1;         end
                2: begin cc = 8'd255; pat = $urandom;      end
                3: begin cc = 8'd0;   pat = 32'h8000_0000; end
                4: begin cc = 8'd1;   pat = 32'd0;         end
                5: begin cc = 8'd3;   pat = $urandom;      end
                default:
                begin
                    cc  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(2, 24));
                    pat = ($urandom_range(0, 7) == 0) ? mdms_pkg::NOTIFY_PATTERN_RESET
                                                      : $urandom;
                end
            endcase
            write_reg(mdms_pkg::CFG_CHANNEL_COUNT, ($urandom & 32'hFFFF_FF00) | {24'd0, cc});
            write_reg(mdms_pkg::CFG_NOTIFY_PATTERN, pat);
            cfg_valid <= 1'b0;
            no_gaps = (p % 3 == 2);
            if (p == 1)
                hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                drive_item(next_sender_item(), 0, NO_RESULT, NO_RESULT);
        end

        in_valid <= 1'b0;
        while (pending_doorbell_ops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("mailbox_doorbell_message_sender_top regression: pass");
        else
            $display("mailbox_doorbell_message_sender_top regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/mdms_pkg.sv
rtl/mdms_framer.sv
rtl/mdms_out_queue.sv
rtl/mailbox_doorbell_message_sender_top.sv
verif/tb_mailbox_doorbell_message_sender_top.sv
